FILE: hdl/keypad_matrix_change_events_core_assert.svh
// ----------------------------------------------------------------------------
// keypad_matrix_change_events_core_assert.svh
// Assertion macros for the keypad change-event core.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_MATRIX_CHANGE_EVENTS_CORE_ASSERT_SVH
`define KEYPAD_MATRIX_CHANGE_EVENTS_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define KMCE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true
`define KMCE_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define KMCE_ASSERT(label, clk, rst_n, prop, msg)
`define KMCE_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

FILE: hdl/kmce_pkg.sv
// ----------------------------------------------------------------------------
// kmce_pkg
// Types, constants and helpers shared by the keypad change-event core.
// ----------------------------------------------------------------------------
`default_nettype none

package kmce_pkg;

  localparam int unsigned ROWS  = 8;
  localparam int unsigned COLS  = 7;
  localparam int unsigned ROW_W = 3;
  localparam int unsigned COL_W = 3;

  typedef logic [COLS-1:0]  row_bits_t;
  typedef logic [ROW_W-1:0] row_idx_t;
  typedef logic [COL_W-1:0] col_idx_t;

  typedef struct packed {
    row_idx_t  scan_row;
    row_bits_t column_levels;
  } kmce_in_t;

  typedef struct packed {
    row_idx_t event_row;
    col_idx_t event_col;
    logic     is_press;
    logic     last_event;
  } kmce_out_t;

  typedef struct packed {
    logic store;
    logic start;
    logic load;
    logic emit;
    logic advance;
    logic commit;
  } kmce_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic mask_zero;
    logic rest_zero;
    logic last_phase;
    logic slot_free;
  } kmce_sts_t;

  // active-low pins to pressed bits; pins 5,6 go to bits 0,1, pins 0..4 to bits 2..6
  function automatic row_bits_t map_row(row_bits_t levels);
    row_bits_t pressed;
    pressed = ~levels;
    return {pressed[4:0], pressed[6:5]};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/keypad_matrix_change_events_core.sv
// ----------------------------------------------------------------------------
// keypad_matrix_change_events_core
// Assembles scanned keypad rows into a key matrix and reports key changes.
// ----------------------------------------------------------------------------
// Row beats are taken while the core is idle. The beat for row 7 closes the scan:
// the core stalls its input, then walks the matrix rows, releases before
// presses, one event beat per cycle through the output register while the
// output is not stalled, and steps over empty release or press groups. The
// walk is set by the single-event output register; the final event has
// last_event set.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keypad_matrix_change_events_core_assert.svh"

module keypad_matrix_change_events_core import kmce_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire kmce_in_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output kmce_out_t     out_item_o
);

  kmce_cmd_t cmd;
  kmce_sts_t sts;

  kmce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kmce_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  `KMCE_ASSERT(a_emit_busy, clk_i, rst_ni, cmd.emit |-> in_stall_o, "event while idle")
  `KMCE_ASSERT(a_emit_slot, clk_i, rst_ni, cmd.emit |-> sts.slot_free, "event overwrites beat")
  `KMCE_ASSERT(a_commit_end, clk_i, rst_ni, cmd.commit |-> sts.last_phase, "early commit")
  `KMCE_ASSERT_NEVER(a_store_busy, clk_i, rst_ni, cmd.store && in_stall_o, "store while busy")

endmodule

`default_nettype wire

FILE: hdl/kmce_dp.sv
// ----------------------------------------------------------------------------
// kmce_dp
// Datapath: current and previous key matrices, event walker, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kmce_dp import kmce_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire kmce_in_t  in_item_i,
  input  wire kmce_cmd_t cmd_i,
  output kmce_sts_t      sts_o,
  input  wire logic      out_stall_i,
  output logic           out_valid_o,
  output kmce_out_t      out_item_o
);

  row_bits_t scan_q [ROWS];
  row_bits_t scan_d [ROWS];
  row_bits_t prev_q [ROWS];
  row_bits_t prev_d [ROWS];
  row_bits_t rel    [ROWS];
  row_bits_t prs    [ROWS];
  logic [ROWS-1:0] diff_any;

  row_idx_t  mr_q, mr_d, mr_next;
  logic      press_q, press_d;
  row_bits_t mask_q, mask_d;
  logic      out_valid_q, out_valid_d;
  kmce_out_t out_q, out_d;

  row_bits_t new_bits, sel_rel, sel_prs, next_vec, low, rest;
  row_idx_t  wr_row;
  col_idx_t  low_idx;
  logic      later, is_last, slot_free;

  always_comb begin
    new_bits = map_row(in_item_i.column_levels);
    wr_row   = row_idx_t'(ROWS - 1) - in_item_i.scan_row;
    for (int i = 0; i < ROWS; i++) begin
      rel[i]      = (scan_q[i] ^ prev_q[i]) & prev_q[i];
      prs[i]      = (scan_q[i] ^ prev_q[i]) & scan_q[i];
      diff_any[i] = |(scan_q[i] ^ prev_q[i]);
    end
    sel_rel  = rel[mr_q];
    sel_prs  = prs[mr_q];
    mr_next  = press_q ? mr_q + row_idx_t'(1) : mr_q;
    next_vec = press_q ? rel[mr_next] : sel_prs;

    low  = mask_q & (~mask_q + row_bits_t'(1));
    rest = mask_q & ~low;
    low_idx = '0;
    for (int c = 0; c < COLS; c++) begin
      if (low[c]) begin
        low_idx = col_idx_t'(c);
      end
    end
    later = 1'b0;
    for (int i = 0; i < ROWS; i++) begin
      if (row_idx_t'(i) > mr_q) begin
        later = later | diff_any[i];
      end
    end
    is_last   = (rest == '0) && !(!press_q && (sel_prs != '0)) && !later;
    slot_free = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      scan_d[i] = scan_q[i];
      prev_d[i] = prev_q[i];
      if (cmd_i.store) begin
        if (in_item_i.scan_row == '0) begin
          scan_d[i] = '0;
        end
        if (row_idx_t'(i) == wr_row) begin
          scan_d[i] = scan_d[i] | new_bits;
        end
      end
      if (cmd_i.commit) begin
        prev_d[i] = scan_q[i];
      end
    end

    mr_d    = mr_q;
    press_d = press_q;
    mask_d  = mask_q;
    if (cmd_i.start) begin
      mr_d    = '0;
      press_d = 1'b0;
    end
    if (cmd_i.load) begin
      mask_d = press_q ? sel_prs : sel_rel;
    end
    if (cmd_i.emit) begin
      mask_d = rest;
    end
    if (cmd_i.advance) begin
      mr_d    = mr_next;
      press_d = !press_q;
      mask_d  = next_vec;
    end

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (cmd_i.emit) begin
      out_valid_d      = 1'b1;
      out_d.event_row  = mr_q;
      out_d.event_col  = low_idx;
      out_d.is_press   = press_q;
      out_d.last_event = is_last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROWS; i++) begin
        scan_q[i] <= '0;
        prev_q[i] <= '0;
      end
      mr_q        <= '0;
      press_q     <= 1'b0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      scan_q      <= scan_d;
      prev_q      <= prev_d;
      mr_q        <= mr_d;
      press_q     <= press_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign sts_o.scan_end   = in_item_i.scan_row == row_idx_t'(ROWS - 1);
  assign sts_o.mask_zero  = mask_q == '0;
  assign sts_o.rest_zero  = rest == '0;
  assign sts_o.last_phase = (mr_q == row_idx_t'(ROWS - 1)) && press_q;
  assign sts_o.slot_free  = slot_free;
  assign out_valid_o      = out_valid_q;
  assign out_item_o       = out_q;

endmodule

`default_nettype wire

FILE: hdl/kmce_ctrl.sv
// ----------------------------------------------------------------------------
// kmce_ctrl
// Controller: takes rows, then walks the change events after the last row.
// ----------------------------------------------------------------------------
`default_nettype none

module kmce_ctrl import kmce_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire kmce_sts_t sts_i,
  output kmce_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN
  } state_e;

  state_e state_q, state_d;
  logic   stall_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.store = 1'b1;
          if (sts_i.scan_end) begin
            cmd_o.start = 1'b1;
            state_d     = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_RUN;
      end
      ST_RUN: begin
        if (sts_i.mask_zero) begin
          if (sts_i.last_phase) begin
            cmd_o.commit = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
          end
        end else if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.rest_zero) begin
            if (sts_i.last_phase) begin
              cmd_o.commit = 1'b1;
              state_d      = ST_IDLE;
            end else begin
              cmd_o.advance = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= state_d != ST_IDLE;
    end
  end

  assign in_stall_o = stall_q;

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for keypad_matrix_change_events_core.
// Row beats go in through the input channel and a scoreboard of key-change
// events is built alongside them. Every event beat that leaves the core is
// matched field by field against the oldest pending event. Directed scans
// cover the extremes, the column mapping and broken row orders, then random
// scans run with idle cycles on both sides and one long output hold-off.
// ----------------------------------------------------------------------------

module tb;
  import kmce_pkg::*;

  localparam int unsigned SETTLE   = 80;
  localparam int unsigned HOLD     = 300;
  localparam int unsigned WATCHDOG = 4000;
  localparam int unsigned N_RANDOM = 64;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      row_valid = 1'b0;
  logic      row_stall;
  kmce_in_t  row_beat  = '0;
  logic      evt_valid;
  logic      evt_stall = 1'b0;
  kmce_out_t evt_beat;

  kmce_out_t   pending_events [$];
  kmce_out_t   oldest_event;
  row_bits_t   cur_keys [ROWS];
  row_bits_t   prev_keys [ROWS];
  row_bits_t   last_levels [ROWS];
  int unsigned errors      = 0;
  int unsigned rows_sent   = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left   = 0;
  bit          hold_request = 1'b0;
  bit          src_gaps    = 1'b1;
  bit          sink_stalls = 1'b1;

  keypad_matrix_change_events_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (row_valid),
    .in_stall_o  (row_stall),
    .in_item_i   (row_beat),
    .out_valid_o (evt_valid),
    .out_stall_i (evt_stall),
    .out_item_o  (evt_beat)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // store one row, and on row 7 queue the release/press events of the scan
  task automatic track_scan(input kmce_in_t beat);
    row_bits_t pressed_now;
    row_bits_t mask;
    kmce_out_t ev;
    kmce_out_t batch [$];
    if (beat.scan_row == 0) begin
      foreach (cur_keys[i]) cur_keys[i] = '0;
    end
    pressed_now = '0;
    for (int c = 0; c < COLS; c++) begin
      if (!beat.column_levels[c]) pressed_now[(c > 4) ? c - 5 : c + 2] = 1'b1;
    end
    cur_keys[(ROWS - 1) - beat.scan_row] |= pressed_now;
    if (beat.scan_row != ROWS - 1) return;
    for (int mr = 0; mr < ROWS; mr++) begin
      for (int press = 0; press < 2; press++) begin
        mask = (cur_keys[mr] ^ prev_keys[mr]) & (press ? cur_keys[mr] : prev_keys[mr]);
        for (int c = 0; c < COLS; c++) begin
          if (mask[c]) begin
            ev.event_row  = row_idx_t'(mr);
            ev.event_col  = col_idx_t'(c);
            ev.is_press   = press[0];
            ev.last_event = 1'b0;
            batch.push_back(ev);
          end
        end
      end
    end
    if (batch.size() != 0) batch[$].last_event = 1'b1;
    foreach (batch[i]) pending_events.push_back(batch[i]);
    prev_keys = cur_keys;
  endtask

  task automatic send_row(input int unsigned row, input row_bits_t levels);
    kmce_in_t beat;
    beat.scan_row      = row_idx_t'(row);
    beat.column_levels = levels;
    while (src_gaps && $urandom_range(99) < 38) begin
      row_valid <= 1'b0;
      @(posedge clk);
    end
    row_valid <= 1'b1;
    row_beat  <= beat;
    do @(posedge clk); while (row_stall);
    track_scan(beat);
    last_levels[beat.scan_row] = levels;
    rows_sent++;
  endtask

  task automatic wait_events_done();
    row_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic row_bits_t pick_levels(int unsigned row);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45) return last_levels[row];
    if (roll < 60) return last_levels[row] ^ row_bits_t'(1 << $urandom_range(COLS - 1));
    if (roll < 70) return '1;
    if (roll < 78) return '0;
    return row_bits_t'($urandom_range(127));
  endfunction

  task automatic send_random_scan();
    for (int r = 0; r < ROWS; r++) send_row(r, pick_levels(r));
  endtask

  task automatic test_extremes();
    for (int r = 0; r < ROWS; r++) send_row(r, '0);
    // repeated row 7 with nothing new: no events
    send_row(7, '1);
    // rows 1..6 missing, row 0 clears everything
    send_row(0, '1);
    send_row(7, '1);
    wait_events_done();
  endtask

  task automatic test_column_map();
    send_row(0, 7'h7E);
    send_row(1, 7'h77);
    send_row(2, 7'h5F);
    send_row(2, 7'h3F);
    send_row(6, 7'h6F);
    send_row(5, 7'h7B);
    send_row(7, 7'h7D);
    send_row(7, 7'h7F);
    wait_events_done();
  endtask

  task automatic test_back_to_back();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    repeat (3) send_random_scan();
    wait_events_done();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
  endtask

  task automatic test_output_backpressure();
    src_gaps     = 1'b0;
    hold_request = 1'b1;
    for (int r = 0; r < ROWS; r++) send_row(r, '0);
    send_random_scan();
    for (int r = 0; r < ROWS; r++) send_row(r, '1);
    wait_events_done();
    src_gaps = 1'b1;
  endtask

  task automatic test_random_scans();
    int unsigned first;
    first = rows_sent;
    while (rows_sent - first < N_RANDOM) begin
      if ($urandom_range(99) < 80) begin
        send_random_scan();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_row($urandom_range(ROWS - 1), row_bits_t'($urandom_range(127)));
        end
      end
    end
    wait_events_done();
  endtask

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      evt_stall <= 1'b1;
      hold_left--;
    end else begin
      evt_stall <= sink_stalls && ($urandom_range(99) < 38);
    end
  end

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && evt_valid && !evt_stall) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event beat, expected none, actual %p", $time, evt_beat);
        errors++;
      end else begin
        oldest_event = pending_events.pop_front();
        check_field("event_row", oldest_event.event_row, evt_beat.event_row);
        check_field("event_col", oldest_event.event_col, evt_beat.event_col);
        check_field("is_press", oldest_event.is_press, evt_beat.is_press);
        check_field("last_event", oldest_event.last_event, evt_beat.last_event);
      end
    end
  end

  always @(posedge clk) begin
    if ((row_valid && !row_stall) || (evt_valid && !evt_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    foreach (cur_keys[i]) begin
      cur_keys[i]    = '0;
      prev_keys[i]   = '0;
      last_levels[i] = '1;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_column_map();
    test_back_to_back();
    test_output_backpressure();
    test_random_scans();
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
